FILE: sv/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset low disables the check
`define AST_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset low disables the check
`define AST_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lfac_pkg.sv
// Shared types and constants of the largest-fit allocator.
// No dependencies.
package lfac_pkg;

    localparam int LFAC_SEG_MAX = 512;
    localparam int LFAC_REQ_MAX = 1024;
    localparam int LFAC_CW      = 31;
    localparam logic [LFAC_CW-1:0] LFAC_MC_RESET = 31'd65536;

    // one free segment held by a ring cell
    typedef struct packed {
        logic               valid;
        logic [LFAC_CW-1:0] start;
        logic [LFAC_CW-1:0] len;
    } t_seg;

    // grant record word: live flag, start, length
    localparam int LFAC_GW = 1 + 2 * LFAC_CW;

endpackage

FILE: sv/lfac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/lfac_cell.sv
// One cell of the free-segment ring: holds a segment, takes its neighbor's.
// Depends on lfac_pkg.
module lfac_cell import lfac_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_init_en,
    input  t_seg i_init,
    input  logic i_shift,
    input  t_seg i_d,
    output t_seg o_q
);

    t_seg r_seg;

    // reset and rebuild load the init value, otherwise rotate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init_en) begin
            r_seg <= i_init;
        end else if (i_shift) begin
            r_seg <= i_d;
        end
    end

    assign o_q = r_seg;

endmodule

FILE: sv/largest_fit_allocator_coalescing_unit.sv
// Largest-fit allocator with coalescing; free segments live in a rotating ring of cells.
// Allocate: scan rotation, update rotation, result; release: grant RAM read, scan
// rotation, update rotation, or the read alone when it names no live grant.
// One item at a time. Throughput is set by the ring, which moves one segment past the
// head per cycle. Reset and every memory_cells write start a pass clearing the grant
// RAM; no item is taken during it. Depends on lfac_pkg, lfac_cell, lfac_ram.
module largest_fit_allocator_coalescing_unit import lfac_pkg::*; #(
    parameter int SEG_MAX = LFAC_SEG_MAX,
    parameter int REQ_MAX = LFAC_REQ_MAX
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_opcode,
    input  logic [LFAC_CW-1:0] i_alloc_length,
    input  logic [9:0]         i_release_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_granted,
    output logic [LFAC_CW-1:0] o_start_cell,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LFAC_CW-1:0] i_cfg_data
);

    localparam int SEG_W = $clog2(SEG_MAX);
    localparam int RA_W  = $clog2(REQ_MAX);
    localparam int CNT_W = $clog2(REQ_MAX + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLR   = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]         r_state;
    logic [SEG_W-1:0]   r_cnt;
    logic [RA_W-1:0]    r_clr;
    logic [CNT_W-1:0]   r_item;
    logic [CNT_W-1:0]   r_num;
    logic               r_op;
    logic [LFAC_CW-1:0] r_len;
    logic [RA_W-1:0]    r_idx;
    logic               r_idx_ok;
    logic [LFAC_CW-1:0] r_s;
    logic [LFAC_CW-1:0] r_l;
    logic               r_bhave;
    logic [LFAC_CW-1:0] r_bstart;
    logic [LFAC_CW-1:0] r_blen;
    logic               r_prev;
    logic               r_next;
    logic [LFAC_CW-1:0] r_nlen;
    logic               r_spare;
    logic               r_placed;
    logic               r_ov;
    logic               r_gr;
    logic [LFAC_CW-1:0] r_sc;

    logic in_fire, cfg_fire, shift, last;
    t_seg w_head, w_mod, w_init0, w_init_z;
    t_seg w_q [SEG_MAX];
    logic [LFAC_CW-1:0] w_mc;
    logic [LFAC_CW:0]   w_end, w_sl;
    logic w_better, w_fit, w_is_prev, w_is_next;
    logic [31:0] w_idx32;
    logic              ram_we;
    logic [RA_W-1:0]   ram_wa;
    logic [LFAC_GW-1:0] ram_wd, ram_rd;

    // a pending register write keeps items out, so the two never share an edge
    assign in_fire  = i_in_valid && !o_in_stall;
    assign cfg_fire = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE) || (r_state == S_CLR);
    assign shift = (r_state == S_SCAN) || (r_state == S_APPLY);
    assign last  = (r_cnt == SEG_W'(SEG_MAX - 1));
    assign w_idx32 = 32'(i_release_index);

    // rebuild values: cell 0 covers every cell, the rest empty
    assign w_mc     = !i_rst_n ? LFAC_MC_RESET : i_cfg_data;
    assign w_init0  = '{valid: (w_mc != '0), start: LFAC_CW'(1), len: w_mc};
    assign w_init_z = '{valid: 1'b0, start: '0, len: '0};

    // ring: each cell takes its upper neighbor, the last takes the edited head
    for (genvar g = 0; g < SEG_MAX; g++) begin : g_ring
        lfac_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_init_en(cfg_fire),
            .i_init   ((g == 0) ? w_init0 : w_init_z),
            .i_shift  (shift),
            .i_d      ((g == SEG_MAX - 1) ? w_mod : w_q[(g + 1) % SEG_MAX]),
            .o_q      (w_q[g])
        );
    end

    assign w_head = w_q[0];

    // head compares
    assign w_end = {1'b0, w_head.start} + {1'b0, w_head.len};
    assign w_sl  = {1'b0, r_s} + {1'b0, r_l};
    assign w_is_prev = w_head.valid && (w_end == {1'b0, r_s});
    assign w_is_next = w_head.valid && ({1'b0, w_head.start} == w_sl);
    assign w_better  = w_head.valid && (!r_bhave || (w_head.len > r_blen) ||
                       ((w_head.len == r_blen) && (w_head.start > r_bstart)));
    assign w_fit = r_bhave && (r_len != '0) && (r_len <= r_blen);

    // head edit during the update rotation
    always_comb begin
        w_mod = w_head;
        if (r_state == S_APPLY) begin
            if (!r_op) begin
                if (w_fit && w_head.valid && (w_head.start == r_bstart)) begin
                    if (w_head.len == r_len) begin
                        w_mod.valid = 1'b0;
                    end else begin
                        w_mod.start = w_head.start + r_len;
                        w_mod.len   = w_head.len - r_len;
                    end
                end
            end else if (r_prev && r_next) begin
                if (w_is_prev) begin
                    w_mod.len = w_head.len + r_l + r_nlen;
                end else if (w_is_next) begin
                    w_mod.valid = 1'b0;
                end
            end else if (r_prev) begin
                if (w_is_prev) begin
                    w_mod.len = w_head.len + r_l;
                end
            end else if (r_next) begin
                if (w_is_next) begin
                    w_mod.start = r_s;
                    w_mod.len   = w_head.len + r_l;
                end
            end else if (r_spare && !r_placed && !w_head.valid) begin
                w_mod = '{valid: 1'b1, start: r_s, len: r_l};
            end
        end
    end

    // grant RAM write port: clearing pass, grant record, release
    always_comb begin
        ram_we = 1'b0;
        ram_wa = r_idx;
        ram_wd = '0;
        if (r_state == S_CLR) begin
            ram_we = !cfg_fire;
            ram_wa = r_clr;
        end else if (r_state == S_DONE) begin
            if (!r_op) begin
                ram_we = (!r_ov || !i_out_stall) && w_fit && (r_num < CNT_W'(REQ_MAX));
                ram_wa = r_num[RA_W-1:0];
                ram_wd = {1'b1, r_bstart, r_len};
            end else begin
                ram_we = r_prev || r_next || r_spare;
            end
        end
    end

    lfac_ram #(.WIDTH(LFAC_GW), .DEPTH(REQ_MAX)) u_grant (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_wa),
        .i_wdata(ram_wd),
        .i_raddr(w_idx32[RA_W-1:0]),
        .o_rdata(ram_rd)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_item  <= '0;
            r_ov    <= 1'b0;
        end else begin
            // result transfer, unless a new result loads in the same cycle
            if (r_ov && !i_out_stall && !((r_state == S_DONE) && !r_op)) begin
                r_ov <= 1'b0;
            end
            // rebuild: ring reloads in the cells, grant RAM gets a clearing pass
            if (cfg_fire) begin
                r_state <= S_CLR;
                r_clr   <= '0;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (in_fire) begin
                            r_op     <= i_opcode;
                            r_len    <= i_alloc_length;
                            r_idx    <= w_idx32[RA_W-1:0];
                            r_idx_ok <= (w_idx32 < 32'(REQ_MAX));
                            r_num    <= r_item;
                            if (r_item != CNT_W'(REQ_MAX)) begin
                                r_item <= r_item + 1'b1;
                            end
                            r_bhave  <= 1'b0;
                            r_prev   <= 1'b0;
                            r_next   <= 1'b0;
                            r_spare  <= 1'b0;
                            r_placed <= 1'b0;
                            r_cnt    <= '0;
                            r_state  <= i_opcode ? S_RD : S_SCAN;
                        end
                    end
                    S_CLR: begin
                        if (r_clr == RA_W'(REQ_MAX - 1)) begin
                            r_state <= S_IDLE;
                        end
                        r_clr <= r_clr + 1'b1;
                    end
                    S_RD: begin
                        r_s <= ram_rd[2*LFAC_CW-1:LFAC_CW];
                        r_l <= ram_rd[LFAC_CW-1:0];
                        r_state <= (r_idx_ok && ram_rd[LFAC_GW-1]) ? S_SCAN : S_IDLE;
                    end
                    S_SCAN: begin
                        if (!r_op) begin
                            if (w_better) begin
                                r_bhave  <= 1'b1;
                                r_bstart <= w_head.start;
                                r_blen   <= w_head.len;
                            end
                        end else begin
                            if (w_is_prev) begin
                                r_prev <= 1'b1;
                            end
                            if (w_is_next) begin
                                r_next <= 1'b1;
                                r_nlen <= w_head.len;
                            end
                            if (!w_head.valid) begin
                                r_spare <= 1'b1;
                            end
                        end
                        if (last) begin
                            r_cnt   <= '0;
                            r_state <= S_APPLY;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    S_APPLY: begin
                        if (r_op && !r_prev && !r_next && r_spare && !w_head.valid) begin
                            r_placed <= 1'b1;
                        end
                        if (last) begin
                            r_cnt   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    S_DONE: begin
                        if (r_op) begin
                            r_state <= S_IDLE;
                        end else if (!r_ov || !i_out_stall) begin
                            r_ov    <= 1'b1;
                            r_gr    <= w_fit;
                            r_sc    <= w_fit ? r_bstart : '0;
                            r_state <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign o_out_valid  = r_ov;
    assign o_granted    = r_gr;
    assign o_start_cell = r_sc;

endmodule

FILE: sv/lfac_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lfac_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_granted,
    input logic [30:0] o_start_cell,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready
);

    // a stalled result holds
    `AST_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_start_cell), "result changed while stalled")
    // refusal carries a zero start, a grant never does
    `AST_IMP(a_refuse_zero, i_clk, i_rst_n, o_out_valid && !o_granted, o_start_cell == 31'd0, "refusal with nonzero start")
    `AST_IMP(a_grant_nz, i_clk, i_rst_n, o_out_valid && o_granted, o_start_cell != 31'd0, "grant at cell zero")
    // an accepted item keeps the block busy
    `AST_NXT(a_busy_item, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken right after a transfer")
    // a register write starts the clearing pass
    `AST_NXT(a_busy_cfg, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready, o_in_stall, "input open right after rebuild")

endmodule

bind largest_fit_allocator_coalescing_unit lfac_checker u_lfac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_granted   (o_granted),
    .o_start_cell(o_start_cell),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);
